[rtl/boolean_expression_stack_evaluator_macros.svh]
// assertion helpers shared by the rtl
`ifndef BOOLEAN_EXPRESSION_STACK_EVALUATOR_MACROS_SVH
`define BOOLEAN_EXPRESSION_STACK_EVALUATOR_MACROS_SVH

// condition holds at every edge out of reset
`define BESEV_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (cond)) else $error(msg);

// antecedent at one edge, consequent at the next
`define BESEV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/besev_pkg.sv]
package besev_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int VAR_W       = 52;
	localparam int SYM_W       = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int LETTERS     = 26;

	localparam logic [SYM_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [SYM_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [SYM_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [SYM_W-1:0] CH_UPPER_Z = 8'h5a;
	localparam logic [SYM_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE    = 8'h39;
	localparam logic [SYM_W-1:0] CH_SEMI    = 8'h3b;
	localparam logic [SYM_W-1:0] CH_BANG    = 8'h21;
	localparam logic [SYM_W-1:0] CH_AMP     = 8'h26;
	localparam logic [SYM_W-1:0] CH_BAR     = 8'h7c;
	localparam logic [SYM_W-1:0] CH_GT      = 8'h3e;
	localparam logic [SYM_W-1:0] CH_PLUS    = 8'h2b;

	localparam logic REG_VARS = 1'b0;
	localparam logic REG_MODE = 1'b1;

	typedef enum logic [1:0] {
		K_NOP,
		K_PUSH,
		K_NEG,
		K_BIN
	} kind_t;

	typedef enum logic [1:0] {
		OP_AND,
		OP_OR,
		OP_IMP,
		OP_XOR
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_OVERFLOW,
		ST_NEG_EMPTY
	} status_t;

	typedef struct packed {
		kind_t kind;
		op_t   op;
		logic  val;
		logic  last;
	} qent_t;

endpackage

[rtl/besev_front.sv]
module besev_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [besev_pkg::SYM_W-1:0]      symbol,
	input  logic                             final_symbol,
	input  logic [besev_pkg::VAR_W-1:0]      variable_values,
	output besev_pkg::qent_t                 entry
);
	import besev_pkg::*;

	logic pend_present_q;
	logic pend_bit_q;
	logic pend_present_n;
	logic pend_bit_n;
	logic [5:0] var_idx;
	logic is_lower;
	logic is_upper;
	logic is_digit;

	assign is_lower = (symbol >= CH_LOWER_A) && (symbol <= CH_LOWER_Z);
	assign is_upper = (symbol >= CH_UPPER_A) && (symbol <= CH_UPPER_Z);
	assign is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);

	always_comb begin
		if (is_upper) begin
			var_idx = 6'(symbol - CH_UPPER_A) + 6'(LETTERS);
		end else begin
			var_idx = 6'(symbol - CH_LOWER_A);
		end
	end

	always_comb begin
		entry.kind     = K_NOP;
		entry.op       = OP_AND;
		entry.val      = pend_bit_q;
		entry.last     = final_symbol;
		pend_present_n = pend_present_q;
		pend_bit_n     = pend_bit_q;
		if (is_lower || is_upper) begin
			pend_present_n = 1'b1;
			pend_bit_n     = pend_bit_q | variable_values[var_idx];
		end else if (is_digit) begin
			pend_present_n = 1'b1;
			pend_bit_n     = pend_bit_q | (symbol != CH_ZERO);
		end else begin
			case (symbol)
				CH_SEMI: begin
					if (pend_present_q) begin
						entry.kind = K_PUSH;
					end
					pend_present_n = 1'b0;
					pend_bit_n     = 1'b0;
				end
				CH_BANG: entry.kind = K_NEG;
				CH_AMP: begin
					entry.kind = K_BIN;
					entry.op   = OP_AND;
				end
				CH_BAR: begin
					entry.kind = K_BIN;
					entry.op   = OP_OR;
				end
				CH_GT: begin
					entry.kind = K_BIN;
					entry.op   = OP_IMP;
				end
				CH_PLUS: begin
					entry.kind = K_BIN;
					entry.op   = OP_XOR;
				end
				default: entry.kind = K_NOP;
			endcase
		end
	end

	// pending operand, dropped at the end of an expression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_present_q <= 1'b0;
			pend_bit_q     <= 1'b0;
		end else if (accept) begin
			if (final_symbol) begin
				pend_present_q <= 1'b0;
				pend_bit_q     <= 1'b0;
			end else begin
				pend_present_q <= pend_present_n;
				pend_bit_q     <= pend_bit_n;
			end
		end
	end

endmodule

[rtl/besev_queue.sv]
`include "boolean_expression_stack_evaluator_macros.svh"

module besev_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  besev_pkg::qent_t  wr_entry,
	output logic              full,
	input  logic              rd,
	output logic              not_empty,
	output besev_pkg::qent_t  rd_entry
);
	import besev_pkg::*;

	qent_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QLVL_W-1:0] level_q;

	assign full      = (level_q == QLVL_W'(QUEUE_DEPTH));
	assign not_empty = (level_q != '0);
	assign rd_entry  = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[tail_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			if (wr) begin
				tail_q <= (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (rd) begin
				head_q <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (wr && !rd) begin
				level_q <= level_q + 1'b1;
			end else if (rd && !wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	`BESEV_ASSERT_ALWAYS(a_level_bound, clk, arst_n,
		level_q <= QLVL_W'(QUEUE_DEPTH), "queue level beyond depth")
	`BESEV_ASSERT_NEXT(a_level_grow, clk, arst_n, wr && !rd,
		level_q == $past(level_q) + 1'b1, "queue level did not grow on write")

endmodule

[rtl/besev_back.sv]
`include "boolean_expression_stack_evaluator_macros.svh"

module besev_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    postfix_mode,
	input  logic                    q_not_empty,
	input  besev_pkg::qent_t        q_entry,
	output logic                    q_rd,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_truth,
	output besev_pkg::status_t      out_status
);
	import besev_pkg::*;

	logic [STACK_DEPTH-1:0] stack_q;
	logic [CNT_W-1:0]       count_q;
	status_t                sticky_q;
	logic                   out_valid_q;
	logic                   out_truth_q;
	status_t                out_status_q;

	logic [STACK_DEPTH-1:0] stack_n;
	logic [CNT_W-1:0]       count_n;
	status_t                sticky_n;
	logic                   lhs;
	logic                   rhs;
	logic                   comb_bit;
	logic                   res_truth;
	status_t                res_status;
	logic                   do_last;

	// a final word waits until the output register is free
	assign q_rd    = q_not_empty && (!q_entry.last || !out_valid_q || out_ready);
	assign do_last = q_rd && q_entry.last;

	assign out_valid  = out_valid_q;
	assign out_truth  = out_truth_q;
	assign out_status = out_status_q;

	// index 0 is the top of the stack
	assign lhs = postfix_mode ? stack_q[1] : stack_q[0];
	assign rhs = postfix_mode ? stack_q[0] : stack_q[1];

	always_comb begin
		case (q_entry.op)
			OP_AND:  comb_bit = lhs & rhs;
			OP_OR:   comb_bit = lhs | rhs;
			OP_IMP:  comb_bit = ~lhs | rhs;
			OP_XOR:  comb_bit = lhs ^ rhs;
			default: comb_bit = lhs ^ rhs;
		endcase
	end

	always_comb begin
		stack_n  = stack_q;
		count_n  = count_q;
		sticky_n = sticky_q;
		case (q_entry.kind)
			K_PUSH: begin
				if (count_q >= CNT_W'(STACK_DEPTH)) begin
					if (sticky_q == ST_OK) begin
						sticky_n = ST_OVERFLOW;
					end
				end else begin
					stack_n = (stack_q << 1) | STACK_DEPTH'(q_entry.val);
					count_n = count_q + 1'b1;
				end
			end
			K_NEG: begin
				if (count_q == '0) begin
					if (sticky_q == ST_OK) begin
						sticky_n = ST_NEG_EMPTY;
					end
				end else begin
					stack_n[0] = ~stack_q[0];
				end
			end
			K_BIN: begin
				if (count_q >= CNT_W'(2)) begin
					stack_n    = stack_q >> 1;
					stack_n[0] = comb_bit;
					count_n    = count_q - 1'b1;
				end
			end
			default: ;
		endcase
		res_truth = (count_n != '0) & stack_n[0];
		if (sticky_n != ST_OK) begin
			res_status = sticky_n;
		end else if (count_n == '0) begin
			res_status = ST_EMPTY;
		end else begin
			res_status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_q  <= '0;
			count_q  <= '0;
			sticky_q <= ST_OK;
		end else if (q_rd) begin
			if (q_entry.last) begin
				stack_q  <= '0;
				count_q  <= '0;
				sticky_q <= ST_OK;
			end else begin
				stack_q  <= stack_n;
				count_q  <= count_n;
				sticky_q <= sticky_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_last) begin
			out_truth_q  <= res_truth;
			out_status_q <= res_status;
		end
	end

	`BESEV_ASSERT_ALWAYS(a_count_bound, clk, arst_n,
		count_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
	`BESEV_ASSERT_ALWAYS(a_unused_zero, clk, arst_n,
		(stack_q >> count_q) == '0, "stack bits above count not clear")
	`BESEV_ASSERT_NEXT(a_end_clear, clk, arst_n, do_last,
		(count_q == '0) && (sticky_q == ST_OK) && out_valid_q,
		"expression state not cleared at end")

endmodule

[rtl/boolean_expression_stack_evaluator.sv]
// Boolean expression evaluator on a bit stack.
// Input stream: one character per word, s_tdata[7:0] the character, s_tlast on
// the final character of an expression. Letters and digits build an operand,
// ';' pushes it, '& | > +' combine the top two entries, '!' inverts the top.
// Output stream: one word per expression, m_tdata[0] truth, m_tdata[2:1] status
// (0 ok, 1 empty stack, 2 overflow, 3 negation on empty).
// Configuration: wr_en with wr_index 0 loads the 52 letter values, index 1 the
// mode bit (1 postfix, 0 prefix fed last character first). Write only while idle.
// Throughput: one character per cycle while the queue is not full. The front
// classifies a character in the cycle it is accepted, a four-word queue decouples
// it from the stack unit, which executes one queued word per cycle unless a final
// word waits for a free output register. m_tvalid is registered after the queue.
// Reset clears the stack, pending operand and output; letters read 0, mode postfix.
// When m_tready is low the result is held; the stack unit keeps running on the
// following expression until it reaches that expression's final character, then
// the queue fills and s_tready drops.
module boolean_expression_stack_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] symbol
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // [0] truth, [2:1] status
	input  logic                          wr_en,
	input  logic                          wr_index,
	input  logic [besev_pkg::VAR_W-1:0]   wr_data
);
	import besev_pkg::*;

	logic [VAR_W-1:0] vars_q;
	logic             postfix_q;
	logic             s_accept;
	qent_t            fr_entry;
	qent_t            q_entry;
	logic             q_full;
	logic             q_not_empty;
	logic             q_rd;
	logic             res_truth;
	status_t          res_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q    <= '0;
			postfix_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				REG_VARS: vars_q    <= wr_data;
				REG_MODE: postfix_q <= wr_data[0];
				default:  ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;

	besev_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (s_accept),
		.symbol          (s_tdata),
		.final_symbol    (s_tlast),
		.variable_values (vars_q),
		.entry           (fr_entry)
	);

	besev_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (s_accept),
		.wr_entry  (fr_entry),
		.full      (q_full),
		.rd        (q_rd),
		.not_empty (q_not_empty),
		.rd_entry  (q_entry)
	);

	besev_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.postfix_mode (postfix_q),
		.q_not_empty  (q_not_empty),
		.q_entry      (q_entry),
		.q_rd         (q_rd),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_truth    (res_truth),
		.out_status   (res_status)
	);

	assign m_tdata = {5'b0, res_status, res_truth};

endmodule
